// File: design/sit_pkg.sv
// Shared types and constants for the sorted insert table.
package sit_pkg;

    localparam int CAP_W      = 7;
    localparam int POS_W      = 6;
    localparam int CNT_OUT_W  = 7;
    localparam int KEY_PORT_W = 32;
    localparam int STATUS_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic ins;       // insert commits this cycle
        logic rem;       // remove commits this cycle
        logic occupied;  // cell index below count
        logic from_pos;  // cell index at or above remove position
    } cell_ctl_t;

endpackage

// File: design/sorted_insert_table_unit.sv
// Top level of the sorted insert table: cell chain, count, capacity and result register.
// Keeps up to DEPTH unsigned keys in ascending order in a chain of cells, one key per
// cell. Insert and remove shift only the cells from the insert slot or remove position
// on, in the accepting cycle, and lookup selects one cell through a one-hot select into
// the result register. A new beat is taken each cycle while the result register is
// empty or being drained, so the sustained rate is one beat per cycle. There is no
// clearing pass after reset; entries at or beyond the count are never reported.
module sorted_insert_table_unit #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sit_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_kind,
    input  logic [sit_pkg::KEY_PORT_W-1:0]     s_key_value,
    input  logic [sit_pkg::POS_W-1:0]          s_position,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sit_pkg::KEY_PORT_W-1:0]     m_read_key,
    output logic [sit_pkg::STATUS_W-1:0]       m_status,
    output logic [sit_pkg::CNT_OUT_W-1:0]      m_entry_count
);
    import sit_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int PCMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(DEPTH);
    localparam logic [PCMP_W-1:0] DEPTH_P = PCMP_W'(DEPTH);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CAP_W-1:0]      cap_reg;
    logic                  m_valid_reg;
    logic [KEY_PORT_W-1:0] m_read_key_reg, m_read_key_next;
    status_t               m_status_reg, m_status_next;
    logic [CNT_OUT_W-1:0]  m_entry_count_reg;

    logic                  accept;
    kind_t                 kind;
    logic [KEY_WIDTH-1:0]  key_in;
    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      count_c;
    logic [PCMP_W-1:0]     count_p;
    logic [PCMP_W-1:0]     pos_p;
    logic                  ins_ok, rem_ok, pos_ok;
    logic [KEY_WIDTH-1:0]  rd_key;

    logic [KEY_WIDTH-1:0]  key_w [DEPTH];
    logic                  go_w  [DEPTH];
    logic [DEPTH-1:0]      sel_w;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign kind    = kind_t'(s_kind);
    assign key_in  = KEY_WIDTH'(s_key_value);

    assign count_c = CMP_W'(count_reg);
    assign count_p = PCMP_W'(count_reg);
    assign pos_p   = PCMP_W'(s_position);
    assign cap_eff = (CMP_W'(cap_reg) > DEPTH_C) ? DEPTH_C : CMP_W'(cap_reg);

    assign pos_ok = (pos_p < count_p) && (pos_p < DEPTH_P);
    assign ins_ok = accept && (kind == KIND_INSERT) && (count_c < cap_eff);
    assign rem_ok = accept && (kind == KIND_REMOVE) && pos_ok;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctl_t ctl;

        assign ctl.ins      = ins_ok;
        assign ctl.rem      = rem_ok;
        assign ctl.occupied = (PCMP_W'(i) < count_p);
        assign ctl.from_pos = (PCMP_W'(i) >= pos_p);
        assign sel_w[i]     = (PCMP_W'(i) == pos_p);

        sit_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .key_in    (key_in),
            .left_key  ((i == 0) ? '0 : key_w[(i == 0) ? 0 : i - 1]),
            .left_go   ((i == 0) ? 1'b0 : go_w[(i == 0) ? 0 : i - 1]),
            .right_key (key_w[(i == DEPTH - 1) ? i : i + 1]),
            .key_out   (key_w[i]),
            .go        (go_w[i])
        );
    end

    // one-hot read of the addressed cell
    always_comb begin
        rd_key = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_key = rd_key | (key_w[i] & {KEY_WIDTH{sel_w[i]}});
        end
    end

    always_comb begin
        count_next      = count_reg;
        m_read_key_next = '0;
        m_status_next   = ST_OK;
        case (kind)
            KIND_INSERT: begin
                if (ins_ok) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    m_status_next = ST_FULL;
                end
            end
            KIND_LOOKUP: begin
                if (pos_ok) begin
                    m_read_key_next = KEY_PORT_W'(rd_key);
                end else begin
                    m_status_next = ST_RANGE;
                end
            end
            KIND_REMOVE: begin
                if (rem_ok) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    m_status_next = ST_RANGE;
                end
            end
            default: begin
                m_status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_key_reg    <= m_read_key_next;
            m_status_reg      <= m_status_next;
            m_entry_count_reg <= CNT_OUT_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_key    = m_read_key_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= DEPTH_C)
        else $error("count exceeds depth");

    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted beat produced no result");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_ok |=> (count_reg == $past(count_reg) + 1'b1) && (m_status == ST_OK))
        else $error("insert did not advance count");

    a_refused_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !ins_ok && !rem_ok |=> $stable(count_reg))
        else $error("count changed without a committed insert or remove");

endmodule

// File: design/sit_cell.sv
// One storage cell of the sorted chain: holds a key and shifts with its neighbors.
module sit_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 aclk,
    input  sit_pkg::cell_ctl_t   ctl,
    input  logic [KEY_WIDTH-1:0] key_in,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_go,
    input  logic [KEY_WIDTH-1:0] right_key,
    output logic [KEY_WIDTH-1:0] key_out,
    output logic                 go
);
    import sit_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    // go: this cell sits at or after the insert slot
    assign go      = !(ctl.occupied && (key_reg < key_in));
    assign key_out = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctl.ins && go) begin
            key_next = left_go ? left_key : key_in;
        end else if (ctl.rem && ctl.from_pos) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule
